[rtl/core/usb_midi_event_packer_assert.svh]
// assertion macros for the usb midi event packer checker
`ifndef USB_MIDI_EVENT_PACKER_ASSERT_SVH
`define USB_MIDI_EVENT_PACKER_ASSERT_SVH

// same-cycle implication, skipped during reset
`define UMEP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped during reset
`define UMEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/umep_pkg.sv]
`timescale 1ns / 1ps

package umep_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CABLE = 2'd1,
    ST_BAD_MSG   = 2'd2
  } status_t;

  localparam logic [7:0] SX_START = 8'hF0;
  localparam logic [7:0] SX_END   = 8'hF7;

  localparam logic [7:0] SYS_MTC_QF    = 8'hF1;
  localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
  localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;
  localparam logic [7:0] SYS_TUNE_REQ  = 8'hF6;
  localparam logic [7:0] RT_CLOCK      = 8'hF8;
  localparam logic [7:0] RT_START      = 8'hFA;
  localparam logic [7:0] RT_CONTINUE   = 8'hFB;
  localparam logic [7:0] RT_STOP       = 8'hFC;
  localparam logic [7:0] RT_SENSING    = 8'hFE;
  localparam logic [7:0] RT_RESET      = 8'hFF;

  localparam logic [3:0] CIN_NONE      = 4'h0;
  localparam logic [3:0] CIN_SYS_TWO   = 4'h2;
  localparam logic [3:0] CIN_SYS_THREE = 4'h3;
  localparam logic [3:0] CIN_SX_CONT   = 4'h4;
  localparam logic [3:0] CIN_ONE_BYTE  = 4'h5;
  localparam logic [3:0] CIN_SX_END2   = 4'h6;
  localparam logic [3:0] CIN_SX_END3   = 4'h7;
  localparam logic [3:0] CIN_PGM_CHG   = 4'hC;
  localparam logic [3:0] CIN_CH_PRESS  = 4'hD;
  localparam logic [3:0] CIN_SINGLE    = 4'hF;

  typedef struct packed {
    logic [7:0] midi_byte0;
    logic [7:0] midi_byte1;
    logic [7:0] midi_byte2;
    logic [7:0] cable_number;
  } event_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] header_byte;
    logic [7:0] packet_byte1;
    logic [7:0] packet_byte2;
    logic [7:0] packet_byte3;
    logic [1:0] message_length;
  } packet_t;

endpackage

[rtl/core/umep_event_if.sv]
`timescale 1ns / 1ps

interface umep_event_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte0;
  logic [7:0] midi_byte1;
  logic [7:0] midi_byte2;
  logic [7:0] cable_number;

  modport source (
    output valid, midi_byte0, midi_byte1, midi_byte2, cable_number,
    input  ready
  );

  modport sink (
    input  valid, midi_byte0, midi_byte1, midi_byte2, cable_number,
    output ready
  );
endinterface

[rtl/core/umep_packet_if.sv]
`timescale 1ns / 1ps

interface umep_packet_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] header_byte;
  logic [7:0] packet_byte1;
  logic [7:0] packet_byte2;
  logic [7:0] packet_byte3;
  logic [1:0] message_length;

  modport source (
    output valid, status, header_byte, packet_byte1, packet_byte2, packet_byte3,
    output message_length,
    input  ready
  );

  modport sink (
    input  valid, status, header_byte, packet_byte1, packet_byte2, packet_byte3,
    input  message_length,
    output ready
  );
endinterface

[rtl/core/usb_midi_event_packer.sv]
// USB MIDI event packer: turns up to three MIDI bytes and a virtual cable
// number into one four-byte USB MIDI event packet (header = cable << 4 | code
// index number, then the carried MIDI bytes zero padded) with a status code
// and the carried byte count. Every input beat yields exactly one output beat,
// in order. The block takes one beat per clock while the output is not stalled;
// each beat passes through the input register and then the output register,
// with the whole decode in combinational logic between.
// The input register refills in the cycle that it hands its beat on, so beats
// stream back to back; while a result waits at the output, one more beat is
// taken into an empty input register and then the input stalls.
// Cable numbers of 16 or more report a bad cable, any
// unrecognized byte pattern a bad message; either error zeroes all other fields.
`timescale 1ns / 1ps

module usb_midi_event_packer (
  input  logic          clk,
  input  logic          rst,
  umep_event_if.sink    event_in,
  umep_packet_if.source packet_out
);

  logic              in_valid;
  umep_pkg::event_t  in_reg;
  logic              out_valid;
  umep_pkg::packet_t out_reg;
  umep_pkg::packet_t enc;
  logic              out_free;
  logic              in_free;

  assign out_free = ~out_valid | packet_out.ready;
  assign in_free  = ~in_valid | out_free;

  assign event_in.ready = in_free;

  umep_encoder u_encoder (
    .evt (in_reg),
    .pkt (enc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid <= event_in.valid;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && event_in.valid) begin
      in_reg <= '{midi_byte0:   event_in.midi_byte0,
                  midi_byte1:   event_in.midi_byte1,
                  midi_byte2:   event_in.midi_byte2,
                  cable_number: event_in.cable_number};
    end
    if (out_free && in_valid) begin
      out_reg <= enc;
    end
  end

  assign packet_out.valid          = out_valid;
  assign packet_out.status         = out_reg.status;
  assign packet_out.header_byte    = out_reg.header_byte;
  assign packet_out.packet_byte1   = out_reg.packet_byte1;
  assign packet_out.packet_byte2   = out_reg.packet_byte2;
  assign packet_out.packet_byte3   = out_reg.packet_byte3;
  assign packet_out.message_length = out_reg.message_length;

endmodule

[rtl/core/umep_encoder.sv]
`timescale 1ns / 1ps

module umep_encoder (
  input  umep_pkg::event_t  evt,
  output umep_pkg::packet_t pkt
);

  logic [3:0] cin;
  logic [1:0] len;
  logic       d0;
  logic       d1;
  logic       d2;

  assign d0 = ~evt.midi_byte0[7];
  assign d1 = ~evt.midi_byte1[7];
  assign d2 = ~evt.midi_byte2[7];

  // code index number, in priority order
  always_comb begin
    cin = umep_pkg::CIN_NONE;
    if (evt.midi_byte0[7:4] inside {[4'h8:4'hE]}) begin
      cin = evt.midi_byte0[7:4];
    end else begin
      case (evt.midi_byte0) inside
        umep_pkg::SYS_MTC_QF, umep_pkg::SYS_SONG_SEL: cin = umep_pkg::CIN_SYS_TWO;
        umep_pkg::SYS_SONG_POS: cin = umep_pkg::CIN_SYS_THREE;
        umep_pkg::SYS_TUNE_REQ: cin = umep_pkg::CIN_ONE_BYTE;
        umep_pkg::RT_CLOCK, umep_pkg::RT_START, umep_pkg::RT_CONTINUE,
        umep_pkg::RT_STOP, umep_pkg::RT_SENSING, umep_pkg::RT_RESET: begin
          cin = umep_pkg::CIN_SINGLE;
        end
        umep_pkg::SX_START: begin
          if (evt.midi_byte1 == umep_pkg::SX_END) begin
            cin = umep_pkg::CIN_SX_END2;
          end else if (d1 && evt.midi_byte2 == umep_pkg::SX_END) begin
            cin = umep_pkg::CIN_SX_END3;
          end else if (d1 && d2) begin
            cin = umep_pkg::CIN_SX_CONT;
          end
        end
        umep_pkg::SX_END: cin = umep_pkg::CIN_ONE_BYTE;
        default: begin
          if (d0) begin
            if (d1 && d2) begin
              cin = umep_pkg::CIN_SX_CONT;
            end else if (d1 && evt.midi_byte2 == umep_pkg::SX_END) begin
              cin = umep_pkg::CIN_SX_END3;
            end else if (evt.midi_byte1 == umep_pkg::SX_END) begin
              cin = umep_pkg::CIN_SX_END2;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    case (cin) inside
      umep_pkg::CIN_NONE: len = 2'd0;
      umep_pkg::CIN_ONE_BYTE, umep_pkg::CIN_SINGLE: len = 2'd1;
      umep_pkg::CIN_SYS_TWO, umep_pkg::CIN_SX_END2, umep_pkg::CIN_PGM_CHG,
      umep_pkg::CIN_CH_PRESS: len = 2'd2;
      default: len = 2'd3;
    endcase
  end

  always_comb begin
    pkt = '0;
    if (evt.cable_number[7:4] != 4'd0) begin
      pkt.status = umep_pkg::ST_BAD_CABLE;
    end else if (len == 2'd0) begin
      pkt.status = umep_pkg::ST_BAD_MSG;
    end else begin
      pkt.status         = umep_pkg::ST_OK;
      pkt.header_byte    = {evt.cable_number[3:0], cin};
      pkt.packet_byte1   = evt.midi_byte0;
      pkt.packet_byte2   = (len >= 2'd2) ? evt.midi_byte1 : 8'd0;
      pkt.packet_byte3   = (len == 2'd3) ? evt.midi_byte2 : 8'd0;
      pkt.message_length = len;
    end
  end

endmodule

[rtl/core/umep_checker.sv]
`timescale 1ns / 1ps
`include "usb_midi_event_packer_assert.svh"

module umep_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [7:0] header_byte,
  input logic [7:0] packet_byte1,
  input logic [7:0] packet_byte2,
  input logic [7:0] packet_byte3,
  input logic [1:0] message_length
);

  logic        beat_ok;
  logic        beat_err;
  logic        ok_shape;
  logic        err_zeroed;
  logic        one_byte;
  logic        pad_zeroed;
  logic        stalled;
  logic [35:0] beat;

  assign beat_ok  = out_valid && status == umep_pkg::ST_OK;
  assign beat_err = out_valid && status != umep_pkg::ST_OK;

  assign ok_shape   = message_length != 2'd0 && header_byte[3:0] != 4'd0;
  assign err_zeroed = header_byte == 8'd0 && packet_byte1 == 8'd0 &&
                      packet_byte2 == 8'd0 && packet_byte3 == 8'd0 &&
                      message_length == 2'd0;
  assign one_byte   = beat_ok && message_length == 2'd1;
  assign pad_zeroed = packet_byte2 == 8'd0 && packet_byte3 == 8'd0;
  assign stalled    = out_valid && !out_ready;
  assign beat       = {status, header_byte, packet_byte1, packet_byte2, packet_byte3,
                       message_length};

  // a good packet always carries bytes and a nonzero code
  `UMEP_ASSERT_NOW(a_ok_has_len, clk, rst, beat_ok, ok_shape, "ok packet with no bytes")

  // errors zero every other field
  `UMEP_ASSERT_NOW(a_err_zero, clk, rst, beat_err, err_zeroed, "error packet not zeroed")

  // padding beyond the carried length of one-byte packets
  `UMEP_ASSERT_NOW(a_pad_zero, clk, rst, one_byte, pad_zeroed, "one byte packet not padded")

  // stalled beat holds
  `UMEP_ASSERT_NEXT(a_hold, clk, rst, stalled, out_valid && $stable(beat), "stalled beat changed")

endmodule

bind usb_midi_event_packer umep_checker u_umep_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (packet_out.valid),
  .out_ready      (packet_out.ready),
  .status         (packet_out.status),
  .header_byte    (packet_out.header_byte),
  .packet_byte1   (packet_out.packet_byte1),
  .packet_byte2   (packet_out.packet_byte2),
  .packet_byte3   (packet_out.packet_byte3),
  .message_length (packet_out.message_length)
);
